### hw/rtl/rrk_pkg.sv
// Shared constants and side-band word types for the razor kinematics core.
// No dependencies; compiled first.
package rrk_pkg;

    localparam int MOMENTUM_WIDTH_DEF = 20;
    localparam int FRACTION_BITS_DEF  = 4;

    localparam int WORK_W   = 20;                  // working momentum width
    localparam int GUARD    = 8;                   // extra fraction bits in roots
    localparam int ARG_W    = 56;                  // first root arguments
    localparam int ROOT_W   = ARG_W / 2;
    localparam int S_W      = 58;                  // S with 16 fraction bits
    localparam int SROOT_W  = S_W / 2;
    localparam int SUM_W    = ROOT_W + 1;
    localparam int ZQ_W     = 29;
    localparam int T_W      = 42;
    localparam int DQ_W     = 48;
    localparam int DOT_W    = 42;
    localparam int MP_W     = ROOT_W + SUM_W;      // |met| * (pta + ptb)
    localparam int X_W      = 60;
    localparam int NUM_W    = 62;                  // divider remainder width
    localparam int QUO_W    = 18;
    localparam int PROD_W   = 100;                 // boost check products

    localparam int MASS_W   = 24;
    localparam int RSQ_W    = 18;
    localparam logic [MASS_W-1:0] MASS_MAX = '1;
    localparam logic [RSQ_W-1:0]  RSQ_MAX  = '1;

    typedef struct packed {
        logic                    ptfail;
        logic [ZQ_W-1:0]         zq;
        logic [T_W-1:0]          t;
        logic [DQ_W-1:0]         dq;
        logic signed [DOT_W-1:0] dot;
    } t_root_side;

    typedef struct packed {
        logic inv;
        logic xpos;
        logic sat;
    } t_div_side;

    typedef struct packed {
        logic             inv;
        logic             xpos;
        logic             sat;
        logic [QUO_W-1:0] quo;
    } t_mass_side;

endpackage

### hw/rtl/rrk_if.sv
// Valid/ready channel interfaces for the razor kinematics core.
// Depends on rrk_pkg.
interface rrk_in_if #(parameter int MOMENTUM_WIDTH = rrk_pkg::MOMENTUM_WIDTH_DEF);
    logic valid;
    logic ready;
    logic signed [MOMENTUM_WIDTH-1:0] a_px, a_py, a_pz;
    logic signed [MOMENTUM_WIDTH-1:0] b_px, b_py, b_pz;
    logic signed [MOMENTUM_WIDTH-1:0] met_x, met_y;
    modport source (output valid, a_px, a_py, a_pz, b_px, b_py, b_pz, met_x, met_y,
                    input ready);
    modport sink   (input valid, a_px, a_py, a_pz, b_px, b_py, b_pz, met_x, met_y,
                    output ready);
endinterface

interface rrk_out_if;
    logic valid;
    logic ready;
    logic [rrk_pkg::MASS_W-1:0] razor_mass;
    logic [rrk_pkg::RSQ_W-1:0]  r_squared;
    logic                       invalid;
    modport source (output valid, razor_mass, r_squared, invalid, input ready);
    modport sink   (input valid, razor_mass, r_squared, invalid, output ready);
endinterface

### hw/rtl/rrk_isqrt_pipe.sv
// Pipelined floor square root, one result bit per stage, several lanes in step.
// A side word rides along with the valid bit. No package dependency.
module rrk_isqrt_pipe #(
    parameter int LANES  = 1,
    parameter int ARG_W  = 56,
    parameter int SIDE_W = 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [LANES*ARG_W-1:0]        i_arg,
    input  logic [SIDE_W-1:0]             i_side,
    output logic                          o_valid,
    output logic [LANES*(ARG_W/2)-1:0]    o_root,
    output logic [SIDE_W-1:0]             o_side
);
    localparam int STAGES = ARG_W / 2;

    logic              r_v    [STAGES];
    logic [SIDE_W-1:0] r_side [STAGES];
    logic [ARG_W-1:0]  r_n    [STAGES][LANES];
    logic [ARG_W-1:0]  r_r    [STAGES][LANES];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        localparam logic [ARG_W-1:0] C_BIT = ARG_W'(1) << (2 * (STAGES - 1 - k));
        logic              p_v;
        logic [SIDE_W-1:0] p_side;
        logic [ARG_W-1:0]  p_n [LANES];
        logic [ARG_W-1:0]  p_r [LANES];
        logic [ARG_W-1:0]  n_n [LANES];
        logic [ARG_W-1:0]  n_r [LANES];

        if (k == 0) begin : g_first
            assign p_v    = i_valid;
            assign p_side = i_side;
            for (genvar l = 0; l < LANES; l++) begin : g_lane
                assign p_n[l] = i_arg[l*ARG_W +: ARG_W];
                assign p_r[l] = '0;
            end
        end else begin : g_next
            assign p_v    = r_v[k-1];
            assign p_side = r_side[k-1];
            for (genvar l = 0; l < LANES; l++) begin : g_lane
                assign p_n[l] = r_n[k-1][l];
                assign p_r[l] = r_r[k-1][l];
            end
        end

        always_comb begin
            logic [ARG_W-1:0] trial;
            for (int l = 0; l < LANES; l++) begin
                trial = p_r[l] + C_BIT;
                if (p_n[l] >= trial) begin
                    n_n[l] = p_n[l] - trial;
                    n_r[l] = (p_r[l] >> 1) + C_BIT;
                end else begin
                    n_n[l] = p_n[l];
                    n_r[l] = p_r[l] >> 1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k] <= p_side;
                for (int l = 0; l < LANES; l++) begin
                    r_n[k][l] <= n_n[l];
                    r_r[k][l] <= n_r[l];
                end
            end
        end
    end

    assign o_valid = r_v[STAGES-1];
    assign o_side  = r_side[STAGES-1];
    for (genvar l = 0; l < LANES; l++) begin : g_out
        assign o_root[l*STAGES +: STAGES] = r_r[STAGES-1][l][STAGES-1:0];
    end

endmodule

### hw/rtl/rrk_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage.
// The divisor and a side word ride along. No package dependency.
module rrk_div_pipe #(
    parameter int NUM_W  = 62,
    parameter int QUO_W  = 18,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [NUM_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [QUO_W-1:0]  o_quo,
    output logic [NUM_W-1:0]  o_den,
    output logic [SIDE_W-1:0] o_side
);
    logic              r_v    [QUO_W];
    logic [NUM_W-1:0]  r_p    [QUO_W];
    logic [NUM_W-1:0]  r_d    [QUO_W];
    logic [QUO_W-1:0]  r_q    [QUO_W];
    logic [SIDE_W-1:0] r_side [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic              p_v;
        logic [NUM_W-1:0]  p_p, p_d, n_p;
        logic [QUO_W-1:0]  p_q, n_q;
        logic [SIDE_W-1:0] p_side;

        if (k == 0) begin : g_first
            assign p_v    = i_valid;
            assign p_p    = i_num;
            assign p_d    = i_den;
            assign p_q    = '0;
            assign p_side = i_side;
        end else begin : g_next
            assign p_v    = r_v[k-1];
            assign p_p    = r_p[k-1];
            assign p_d    = r_d[k-1];
            assign p_q    = r_q[k-1];
            assign p_side = r_side[k-1];
        end

        // remainder stays below the divisor, so the shift never overflows
        always_comb begin
            if (p_p >= p_d) begin
                n_p = (p_p - p_d) << 1;
                n_q = {p_q[QUO_W-2:0], 1'b1};
            end else begin
                n_p = p_p << 1;
                n_q = {p_q[QUO_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_p[k]    <= n_p;
                r_d[k]    <= p_d;
                r_q[k]    <= n_q;
                r_side[k] <= p_side;
            end
        end
    end

    assign o_valid = r_v[QUO_W-1];
    assign o_quo   = r_q[QUO_W-1];
    assign o_den   = r_d[QUO_W-1];
    assign o_side  = r_side[QUO_W-1];

endmodule

### hw/rtl/razor_mr_rsq_kinematics_core.sv
// Razor kinematics core: two massless hemisphere momenta plus missing pt in, MR and R^2 out.
// Depends on rrk_pkg, rrk_if, rrk_isqrt_pipe and rrk_div_pipe.
//
// One event word is accepted per clock and one result word leaves per clock while the
// pipe advances. The path runs through 3 prep stages, 28 stages of the five parallel guard
// roots, 5 stages of products and checks, 18 divider stages for R^2 and 29 stages of the
// mass root, plus the output register. The throughput is set by the bit-per-stage root and
// divider pipelines, which all advance together: the whole pipe moves whenever the output
// register is empty or its word is being taken. An invalid event (leading jet pt at or
// below 0.1 GeV, empty transverse sum, nonpositive S, or a boost faster than light)
// returns mass and R^2 of zero with the invalid flag set. Momenta wider than 20 bits are
// floor-shifted to 20 bits for the work and the mass is shifted back before saturation.
module razor_mr_rsq_kinematics_core #(
    parameter int MOMENTUM_WIDTH = rrk_pkg::MOMENTUM_WIDTH_DEF,
    parameter int FRACTION_BITS  = rrk_pkg::FRACTION_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rrk_in_if.sink        i_in,
    rrk_out_if.source     o_out
);
    import rrk_pkg::*;

    localparam int MW     = MOMENTUM_WIDTH;
    localparam int PRE    = (MW > WORK_W) ? (MW - WORK_W) : 0;
    localparam int PT_THR = (1 << (2 * FRACTION_BITS)) / 100;
    localparam int MEXT_W = SROOT_W + PRE;

    // global advance: the pipe moves when the output slot is free or drained
    logic w_en;
    logic r_out_valid;
    assign w_en       = !r_out_valid || o_out.ready;
    assign i_in.ready = w_en;

    // ---------------- stage A: reduce to working width, full-precision pt squares
    logic signed [MW-1:0]     w_full [8];
    logic signed [WORK_W-1:0] w_red  [8];
    assign w_full[0] = i_in.a_px;
    assign w_full[1] = i_in.a_py;
    assign w_full[2] = i_in.a_pz;
    assign w_full[3] = i_in.b_px;
    assign w_full[4] = i_in.b_py;
    assign w_full[5] = i_in.b_pz;
    assign w_full[6] = i_in.met_x;
    assign w_full[7] = i_in.met_y;

    for (genvar i = 0; i < 8; i++) begin : g_red
        if (MW >= WORK_W) begin : g_shr
            assign w_red[i] = WORK_W'(w_full[i] >>> PRE);
        end else begin : g_ext
            assign w_red[i] = WORK_W'(w_full[i]);
        end
    end

    logic                     r_va;
    logic signed [WORK_W-1:0] r_a_red [8];
    logic signed [2*MW-1:0]   r_a_fsq0, r_a_fsq1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_va <= 1'b0;
        else if (w_en) r_va <= i_in.valid;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_red  <= w_red;
            r_a_fsq0 <= w_full[0] * w_full[0];
            r_a_fsq1 <= w_full[1] * w_full[1];
        end
    end

    // ---------------- stage B: squares of the working values, transverse sums
    logic signed [2*WORK_W-1:0] n_b_sq [8];
    logic signed [WORK_W:0]     n_b_sx, n_b_sy, n_b_zs;
    logic [2*MW-1:0]            n_b_pt;
    always_comb begin
        for (int i = 0; i < 8; i++) n_b_sq[i] = r_a_red[i] * r_a_red[i];
        n_b_sx = (WORK_W+1)'(r_a_red[0]) + (WORK_W+1)'(r_a_red[3]);
        n_b_sy = (WORK_W+1)'(r_a_red[1]) + (WORK_W+1)'(r_a_red[4]);
        n_b_zs = (WORK_W+1)'(r_a_red[2]) + (WORK_W+1)'(r_a_red[5]);
        n_b_pt = unsigned'(r_a_fsq0) + unsigned'(r_a_fsq1);
    end

    logic                       r_vb;
    logic [2*WORK_W-1:0]        r_b_sq [8];
    logic signed [WORK_W:0]     r_b_sx, r_b_sy, r_b_zs;
    logic signed [WORK_W-1:0]   r_b_mx, r_b_my;
    logic                       r_b_ptfail;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vb <= 1'b0;
        else if (w_en) r_vb <= r_va;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 8; i++) r_b_sq[i] <= unsigned'(n_b_sq[i]);
            r_b_sx     <= n_b_sx;
            r_b_sy     <= n_b_sy;
            r_b_zs     <= n_b_zs;
            r_b_mx     <= r_a_red[6];
            r_b_my     <= r_a_red[7];
            r_b_ptfail <= (n_b_pt <= (2*MW)'(PT_THR));
        end
    end

    // ---------------- stage C: root arguments, |aT+bT|^2, pt imbalance, met dot terms
    logic [2*WORK_W:0]   n_c_at2, n_c_bt2, n_c_a3, n_c_b3, n_c_m2;
    logic [2*WORK_W-1:0] n_c_dif;
    logic [WORK_W:0]     n_c_zmag;
    logic signed [2*WORK_W+1:0] n_c_sxx, n_c_syy;
    always_comb begin
        n_c_at2  = (2*WORK_W+1)'(r_b_sq[0]) + (2*WORK_W+1)'(r_b_sq[1]);
        n_c_bt2  = (2*WORK_W+1)'(r_b_sq[3]) + (2*WORK_W+1)'(r_b_sq[4]);
        n_c_a3   = n_c_at2 + (2*WORK_W+1)'(r_b_sq[2]);
        n_c_b3   = n_c_bt2 + (2*WORK_W+1)'(r_b_sq[5]);
        n_c_m2   = (2*WORK_W+1)'(r_b_sq[6]) + (2*WORK_W+1)'(r_b_sq[7]);
        n_c_dif  = (n_c_at2 > n_c_bt2) ? (2*WORK_W)'(n_c_at2 - n_c_bt2)
                                       : (2*WORK_W)'(n_c_bt2 - n_c_at2);
        n_c_zmag = r_b_zs[WORK_W] ? unsigned'(-r_b_zs) : unsigned'(r_b_zs);
        n_c_sxx  = r_b_sx * r_b_sx;
        n_c_syy  = r_b_sy * r_b_sy;
    end

    localparam int LANES_C = 5;
    logic                          r_vc;
    logic [LANES_C*ARG_W-1:0]      r_c_arg;
    logic [T_W-1:0]                r_c_t;
    logic [DQ_W-1:0]               r_c_dq;
    logic [ZQ_W-1:0]               r_c_zq;
    logic signed [2*WORK_W:0]      r_c_m6, r_c_m7;
    logic                          r_c_ptfail;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vc <= 1'b0;
        else if (w_en) r_vc <= r_vb;
    end
    // lanes: A magnitude, B magnitude, |met|, pt(a), pt(b), each times 2^16
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_arg    <= {{n_c_bt2[2*WORK_W-1:0], 16'b0}, {n_c_at2[2*WORK_W-1:0], 16'b0},
                           {n_c_m2[2*WORK_W-1:0], 16'b0},  {n_c_b3[2*WORK_W-1:0], 16'b0},
                           {n_c_a3[2*WORK_W-1:0], 16'b0}};
            r_c_t      <= unsigned'(n_c_sxx) + unsigned'(n_c_syy);
            r_c_dq     <= {n_c_dif, 8'b0};
            r_c_zq     <= {n_c_zmag, 8'b0};
            r_c_m6     <= r_b_mx * r_b_sx;
            r_c_m7     <= r_b_my * r_b_sy;
            r_c_ptfail <= r_b_ptfail;
        end
    end

    // ---------------- five guard roots in step
    t_root_side             w_rs_in, w_rs_out;
    logic                   w_rv;
    logic [LANES_C*ROOT_W-1:0] w_roots;
    assign w_rs_in.ptfail = r_c_ptfail;
    assign w_rs_in.zq     = r_c_zq;
    assign w_rs_in.t      = r_c_t;
    assign w_rs_in.dq     = r_c_dq;
    assign w_rs_in.dot    = DOT_W'(r_c_m6) + DOT_W'(r_c_m7);

    rrk_isqrt_pipe #(
        .LANES (LANES_C),
        .ARG_W (ARG_W),
        .SIDE_W($bits(t_root_side))
    ) u_roots (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_valid(r_vc),
        .i_arg  (r_c_arg),
        .i_side (w_rs_in),
        .o_valid(w_rv),
        .o_root (w_roots),
        .o_side (w_rs_out)
    );

    // ---------------- stage E: sums of roots
    logic             r_ve;
    logic [SUM_W-1:0] r_e_sum, r_e_pab;
    logic [ROOT_W-1:0] r_e_met;
    t_root_side       r_e_side;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ve <= 1'b0;
        else if (w_en) r_ve <= w_rv;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_sum  <= SUM_W'(w_roots[0 +: ROOT_W]) + SUM_W'(w_roots[ROOT_W +: ROOT_W]);
            r_e_met  <= w_roots[2*ROOT_W +: ROOT_W];
            r_e_pab  <= SUM_W'(w_roots[3*ROOT_W +: ROOT_W])
                      + SUM_W'(w_roots[4*ROOT_W +: ROOT_W]);
            r_e_side <= w_rs_out;
        end
    end

    // ---------------- stage F: squares for S, met times pt sum
    logic            r_vf;
    logic [S_W-1:0]  r_f_sumsq, r_f_zqsq;
    logic [MP_W-1:0] r_f_mp;
    logic            r_f_sumpos, r_f_tzero;
    t_root_side      r_f_side;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vf <= 1'b0;
        else if (w_en) r_vf <= r_ve;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_sumsq  <= S_W'(r_e_sum) * S_W'(r_e_sum);
            r_f_zqsq   <= S_W'(r_e_side.zq) * S_W'(r_e_side.zq);
            r_f_mp     <= MP_W'(r_e_met) * MP_W'(r_e_pab);
            r_f_sumpos <= SUM_W'(r_e_side.zq) < r_e_sum;
            r_f_tzero  <= (r_e_side.t == '0);
            r_f_side   <= r_e_side;
        end
    end

    // ---------------- stage G: S and the MTR^2 numerator
    logic                  r_vg;
    logic [S_W-1:0]        r_g_s;
    logic signed [X_W-1:0] r_g_x;
    logic [T_W-1:0]        r_g_t;
    logic [DQ_W-1:0]       r_g_dq;
    logic                  r_g_ok;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vg <= 1'b0;
        else if (w_en) r_vg <= r_vf;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_g_s  <= r_f_sumsq - r_f_zqsq;
            r_g_x  <= $signed({{(X_W-MP_W){1'b0}}, r_f_mp})
                    - $signed({{(X_W-DOT_W-16){r_f_side.dot[DOT_W-1]}}, r_f_side.dot, 16'b0});
            r_g_t  <= r_f_side.t;
            r_g_dq <= r_f_side.dq;
            r_g_ok <= !r_f_side.ptfail && r_f_sumpos && !r_f_tzero;
        end
    end

    // ---------------- stage H: partial products of t*S and dq^2
    logic            r_vh;
    logic [49:0]     r_h_pt00, r_h_pt01, r_h_pt10, r_h_pt11;
    logic [47:0]     r_h_pd00, r_h_pd01, r_h_pd11;
    logic [S_W-1:0]  r_h_s;
    logic signed [X_W-1:0] r_h_x;
    logic            r_h_ok;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vh <= 1'b0;
        else if (w_en) r_vh <= r_vg;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_h_pt00 <= 50'(r_g_t[20:0])  * 50'(r_g_s[28:0]);
            r_h_pt01 <= 50'(r_g_t[20:0])  * 50'(r_g_s[57:29]);
            r_h_pt10 <= 50'(r_g_t[41:21]) * 50'(r_g_s[28:0]);
            r_h_pt11 <= 50'(r_g_t[41:21]) * 50'(r_g_s[57:29]);
            r_h_pd00 <= 48'(r_g_dq[23:0])  * 48'(r_g_dq[23:0]);
            r_h_pd01 <= 48'(r_g_dq[23:0])  * 48'(r_g_dq[47:24]);
            r_h_pd11 <= 48'(r_g_dq[47:24]) * 48'(r_g_dq[47:24]);
            r_h_s    <= r_g_s;
            r_h_x    <= r_g_x;
            r_h_ok   <= r_g_ok;
        end
    end

    // ---------------- stage I: full boost-check products
    logic              r_vi;
    logic [PROD_W-1:0] r_i_lhs, r_i_rhs;
    logic [S_W-1:0]    r_i_s;
    logic signed [X_W-1:0] r_i_x;
    logic              r_i_ok;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vi <= 1'b0;
        else if (w_en) r_vi <= r_vh;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_i_lhs <= PROD_W'(r_h_pt00) + (PROD_W'(r_h_pt01) << 29)
                     + (PROD_W'(r_h_pt10) << 21) + (PROD_W'(r_h_pt11) << 50);
            r_i_rhs <= PROD_W'(r_h_pd00) + (PROD_W'(r_h_pd01) << 25)
                     + (PROD_W'(r_h_pd11) << 48);
            r_i_s   <= r_h_s;
            r_i_x   <= r_h_x;
            r_i_ok  <= r_h_ok;
        end
    end

    // ---------------- R^2 divider: floor(x * 2^15 / S), 18 quotient bits
    t_div_side        w_ds_in, w_ds_out;
    logic [NUM_W-1:0] w_num, w_den, w_den_out;
    logic [QUO_W-1:0] w_quo;
    logic             w_dv;
    assign w_num = {{(NUM_W-X_W){1'b0}}, r_i_x};
    assign w_den = {{(NUM_W-S_W-2){1'b0}}, r_i_s, 2'b0};
    assign w_ds_in.inv  = !(r_i_ok && (r_i_lhs > r_i_rhs));
    assign w_ds_in.xpos = (r_i_x > 0);
    assign w_ds_in.sat  = w_num >= {{(NUM_W-S_W-3){1'b0}}, r_i_s, 3'b0};

    rrk_div_pipe #(
        .NUM_W (NUM_W),
        .QUO_W (QUO_W),
        .SIDE_W($bits(t_div_side))
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_valid(r_vi),
        .i_num  (w_num),
        .i_den  (w_den),
        .i_side (w_ds_in),
        .o_valid(w_dv),
        .o_quo  (w_quo),
        .o_den  (w_den_out),
        .o_side (w_ds_out)
    );

    // ---------------- mass root of S
    t_mass_side         w_ms_in, w_ms_out;
    logic               w_mv;
    logic [SROOT_W-1:0] w_mroot;
    assign w_ms_in.inv  = w_ds_out.inv;
    assign w_ms_in.xpos = w_ds_out.xpos;
    assign w_ms_in.sat  = w_ds_out.sat;
    assign w_ms_in.quo  = w_quo;

    rrk_isqrt_pipe #(
        .LANES (1),
        .ARG_W (S_W),
        .SIDE_W($bits(t_mass_side))
    ) u_mass (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_valid(w_dv),
        .i_arg  (w_den_out[S_W+1:2]),
        .i_side (w_ms_in),
        .o_valid(w_mv),
        .o_root (w_mroot),
        .o_side (w_ms_out)
    );

    // ---------------- output register: scale back, saturate, gate invalid events
    logic [MEXT_W-1:0] w_mext;
    logic [MASS_W-1:0] n_mass;
    logic [RSQ_W-1:0]  n_rsq;
    assign w_mext = (MEXT_W'(w_mroot) << PRE) >> GUARD;

    always_comb begin
        if (w_ms_out.inv) begin
            n_mass = '0;
            n_rsq  = '0;
        end else begin
            n_mass = (w_mext > MEXT_W'(MASS_MAX)) ? MASS_MAX : MASS_W'(w_mext);
            if (!w_ms_out.xpos)     n_rsq = '0;
            else if (w_ms_out.sat)  n_rsq = RSQ_MAX;
            else                    n_rsq = w_ms_out.quo;
        end
    end

    logic [MASS_W-1:0] r_out_mass;
    logic [RSQ_W-1:0]  r_out_rsq;
    logic              r_out_inv;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else if (w_en) r_out_valid <= w_mv;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_mass <= n_mass;
            r_out_rsq  <= n_rsq;
            r_out_inv  <= w_ms_out.inv;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.razor_mass = r_out_mass;
    assign o_out.r_squared  = r_out_rsq;
    assign o_out.invalid    = r_out_inv;

endmodule

### hw/rtl/rrk_checker.sv
// Port-level checks for the razor kinematics core, bound to the top level.
// Depends on rrk_pkg and razor_mr_rsq_kinematics_core.
module rrk_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [rrk_pkg::MASS_W-1:0] i_mass,
    input logic [rrk_pkg::RSQ_W-1:0]  i_rsq,
    input logic                       i_invalid
);
    // invalid words carry zero results
    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_invalid |-> i_mass == '0 && i_rsq == '0)
        else $error("invalid word with nonzero result");

    // a free output slot never blocks the input
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");

    // a waiting word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_mass)
            && $stable(i_rsq) && $stable(i_invalid))
        else $error("output word changed while stalled");

    // nothing leaves right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("output valid right after reset");

endmodule

bind razor_mr_rsq_kinematics_core rrk_checker u_rrk_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_ready (i_in.ready),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_mass     (o_out.razor_mass),
    .i_rsq      (o_out.r_squared),
    .i_invalid  (o_out.invalid)
);
